### sv/smpi_pkg.sv
// Shared types, codes and widths for the min-pc warp issue block.
`default_nettype none

package smpi_pkg;

    // Default geometry of the warp.
    localparam int DEF_LANES   = 32;
    localparam int DEF_PC_BITS = 16;

    // Fixed field widths.
    localparam int PROG_LEN_W = 16;
    localparam int OFFSET_W   = 16;
    localparam int COST_W     = 4;
    localparam int STEP_W     = 32;
    localparam int LANE_OPS_W = 40;
    localparam int WEIGHT_W   = 48;
    localparam int FAULT_W    = 2;

    // Input actions.
    typedef enum logic [1:0] {
        ACT_LAUNCH = 2'd0,
        ACT_RETIRE = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    // Outcome of a retired instruction.
    typedef enum logic [1:0] {
        OUT_FALL   = 2'd0,
        OUT_JUMP   = 2'd1,
        OUT_BRANCH = 2'd2,
        OUT_RETURN = 2'd3
    } outcome_t;

    // Fault codes.
    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE       = 2'd0,
        FAULT_PAST_END   = 2'd1,
        FAULT_NEG_TARGET = 2'd2
    } fault_t;

    // Broadcast control for every lane.
    typedef struct packed {
        logic launch;
        logic apply;
        logic kill;
    } lane_ctl_t;

    // Control for the statistics counters.
    typedef struct packed {
        logic count;
        logic clear;
    } stats_ctl_t;

endpackage

`default_nettype wire

### sv/smpi_lane.sv
// One lane: program counter, live flag and their update for each item.
`default_nettype none

module smpi_lane #(
    parameter int PC_BITS = smpi_pkg::DEF_PC_BITS
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  smpi_pkg::lane_ctl_t     ctl,
    input  wire                     launch_bit,
    input  wire                     issued_bit,
    input  wire                     jump_bit,
    input  wire [PC_BITS-1:0]       start_pc,
    input  wire [PC_BITS-1:0]       jump_pc,
    input  wire [PC_BITS-1:0]       fall_pc,
    output logic [PC_BITS-1:0]      pc_next,
    output logic                    live_next,
    output logic                    live
);
    import smpi_pkg::*;

    logic [PC_BITS-1:0] pc_reg;
    logic               live_reg;

    // Next state of this lane for the item at the input.
    always_comb
    begin
        pc_next   = pc_reg;
        live_next = live_reg;
        if (ctl.launch)
        begin
            live_next = launch_bit;
            if (launch_bit)
            begin
                pc_next = start_pc;
            end
        end
        else if (ctl.apply && issued_bit)
        begin
            if (ctl.kill)
            begin
                live_next = 1'b0;
            end
            else if (jump_bit)
            begin
                pc_next = jump_pc;
            end
            else
            begin
                pc_next = fall_pc;
            end
        end
    end

    // The live flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    // The pc of a lane is only looked at while the lane is live.
    always_ff @(posedge clk)
    begin
        pc_reg <= pc_next;
    end

    assign live = live_reg;

endmodule

`default_nettype wire

### sv/smpi_merge.sv
// Minimum tree over the lanes and mask of live lanes at the minimum pc.
`default_nettype none

module smpi_merge #(
    parameter int LANES   = smpi_pkg::DEF_LANES,
    parameter int PC_BITS = smpi_pkg::DEF_PC_BITS
) (
    input  wire [PC_BITS-1:0]   lane_pc [LANES],
    input  wire [LANES-1:0]     lane_live,
    output logic [PC_BITS-1:0]  min_pc,
    output logic                any_live,
    output logic [LANES-1:0]    min_mask
);
    import smpi_pkg::*;

    localparam int LEAVES = 1 << $clog2(LANES);
    localparam int NODES  = 2 * LEAVES - 1;

    logic [PC_BITS-1:0] node_pc [NODES];
    logic [NODES-1:0]   node_ok;

    // Leaves: one per lane, padding leaves hold nothing.
    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < LANES)
        begin : g_real
            assign node_pc[LEAVES-1+i] = lane_pc[i];
            assign node_ok[LEAVES-1+i] = lane_live[i];
        end
        else
        begin : g_pad
            assign node_pc[LEAVES-1+i] = '0;
            assign node_ok[LEAVES-1+i] = 1'b0;
        end
    end

    // Inner nodes keep the smaller pc of their two live children.
    for (genvar n = 0; n < LEAVES - 1; n++)
    begin : g_node
        logic take_left;
        assign take_left  = node_ok[2*n+1] &&
                            (!node_ok[2*n+2] || (node_pc[2*n+1] <= node_pc[2*n+2]));
        assign node_pc[n] = take_left ? node_pc[2*n+1] : node_pc[2*n+2];
        assign node_ok[n] = node_ok[2*n+1] | node_ok[2*n+2];
    end

    assign any_live = node_ok[0];
    assign min_pc   = node_ok[0] ? node_pc[0] : '0;

    // Lanes that are live and sit at the chosen pc.
    for (genvar i = 0; i < LANES; i++)
    begin : g_mask
        assign min_mask[i] = lane_live[i] && (lane_pc[i] == node_pc[0]);
    end

endmodule

`default_nettype wire

### sv/smpi_stats.sv
// Saturating step, lane and weighted-cost counters.
`default_nettype none

module smpi_stats #(
    parameter int LANES = smpi_pkg::DEF_LANES
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  smpi_pkg::stats_ctl_t            ctl,
    input  wire [LANES-1:0]                 issued_mask,
    input  wire [smpi_pkg::COST_W-1:0]      cost,
    output logic [smpi_pkg::STEP_W-1:0]     step_next,
    output logic [smpi_pkg::LANE_OPS_W-1:0] lane_ops_next,
    output logic [smpi_pkg::WEIGHT_W-1:0]   weighted_next
);
    import smpi_pkg::*;

    localparam int CNT_W = $clog2(LANES + 1);
    localparam int INC_W = CNT_W + COST_W;

    logic [CNT_W-1:0]      lane_cnt;
    logic [INC_W-1:0]      weight_inc;
    logic [STEP_W:0]       step_sum;
    logic [LANE_OPS_W:0]   lane_sum;
    logic [WEIGHT_W:0]     weight_sum;
    logic [STEP_W-1:0]     step_reg;
    logic [LANE_OPS_W-1:0] lane_ops_reg;
    logic [WEIGHT_W-1:0]   weighted_reg;

    // Number of lanes in the issued mask.
    always_comb
    begin
        lane_cnt = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lane_cnt = lane_cnt + CNT_W'(issued_mask[i]);
        end
    end

    assign weight_inc = INC_W'(lane_cnt) * INC_W'(cost);

    // A carry out of each sum means the counter saturates.
    assign step_sum   = {1'b0, step_reg} + (STEP_W + 1)'(1);
    assign lane_sum   = {1'b0, lane_ops_reg} + (LANE_OPS_W + 1)'(lane_cnt);
    assign weight_sum = {1'b0, weighted_reg} + (WEIGHT_W + 1)'(weight_inc);

    always_comb
    begin
        step_next     = step_reg;
        lane_ops_next = lane_ops_reg;
        weighted_next = weighted_reg;
        if (ctl.clear)
        begin
            step_next     = '0;
            lane_ops_next = '0;
            weighted_next = '0;
        end
        else if (ctl.count)
        begin
            step_next     = step_sum[STEP_W] ? '1 : step_sum[STEP_W-1:0];
            lane_ops_next = lane_sum[LANE_OPS_W] ? '1 : lane_sum[LANE_OPS_W-1:0];
            weighted_next = weight_sum[WEIGHT_W] ? '1 : weight_sum[WEIGHT_W-1:0];
        end
    end

    // Counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            lane_ops_reg <= '0;
            weighted_reg <= '0;
        end
        else
        begin
            step_reg     <= step_next;
            lane_ops_reg <= lane_ops_next;
            weighted_reg <= weighted_next;
        end
    end

endmodule

`default_nettype wire

### sv/simt_min_pc_warp_issue.sv
// Top level of the min-pc warp issue block: lanes, minimum tree, counters and result buffer.
`default_nettype none

// Tracks one warp of LANES lanes and, for every accepted item, reports the lowest live
// pc, the lanes sitting at it, the done flag, the fault code and the three statistics
// counters. One item is accepted per clock cycle while in_stall is low; its result is
// held in the output or skid register. The per-cycle path is the lane update followed
// by the log2(LANES)-level minimum tree and the mask compare, all combinational so that
// the next retire sees the freshly issued pc. A two-entry result buffer (output
// register plus skid register) lets the block keep taking items while one result waits;
// in_stall rises only when both entries are full. program_length is written through
// cfg_wr_en/cfg_wr_data and takes effect at the next issue.
module simt_min_pc_warp_issue #(
    parameter int LANES   = smpi_pkg::DEF_LANES,
    parameter int PC_BITS = smpi_pkg::DEF_PC_BITS
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // Configuration.
    input  wire                               cfg_wr_en,
    input  wire [smpi_pkg::PROG_LEN_W-1:0]    cfg_wr_data,
    // Input channel.
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire [1:0]                         action,
    input  wire [PC_BITS-1:0]                 start_pc,
    input  wire [LANES-1:0]                   launch_mask,
    input  wire [1:0]                         outcome_kind,
    input  wire [LANES-1:0]                   taken_mask,
    input  wire [smpi_pkg::OFFSET_W-1:0]      branch_offset,
    input  wire [smpi_pkg::COST_W-1:0]        cost,
    // Output channel.
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [PC_BITS-1:0]                issue_pc,
    output logic [LANES-1:0]                  issue_mask,
    output logic                              warp_done,
    output logic [smpi_pkg::FAULT_W-1:0]      fault_code,
    output logic [smpi_pkg::STEP_W-1:0]       step_count,
    output logic [smpi_pkg::LANE_OPS_W-1:0]   lane_op_count,
    output logic [smpi_pkg::WEIGHT_W-1:0]     weighted_op_count
);
    import smpi_pkg::*;

    localparam int TW    = ((PC_BITS > OFFSET_W) ? PC_BITS : OFFSET_W) + 2;
    localparam int CW    = (PC_BITS > PROG_LEN_W) ? PC_BITS : PROG_LEN_W;
    localparam int RES_W = PC_BITS + LANES + 1 + FAULT_W + STEP_W + LANE_OPS_W + WEIGHT_W;

    // Issue state.
    logic [PROG_LEN_W-1:0] program_length_reg;
    logic [PC_BITS-1:0]    current_pc_reg;
    logic [LANES-1:0]      current_mask_reg;
    fault_t                fault_reg;
    fault_t                fault_mid;
    fault_t                fault_next;

    // Handshake and decode.
    logic       in_acc;
    logic       out_acc;
    logic       is_launch;
    logic       is_retire;
    logic       is_clear;
    logic       retire_hit;
    logic       neg_fault;
    lane_ctl_t  lane_ctl;
    stats_ctl_t stats_ctl;

    // Branch arithmetic.
    logic [LANES-1:0]   jumpers;
    logic [TW-1:0]      target;
    logic               target_neg;
    logic               target_over;
    logic [PC_BITS-1:0] jump_pc;
    logic [PC_BITS-1:0] fall_pc;

    // Lanes and merge.
    logic [PC_BITS-1:0] lane_pc_next [LANES];
    logic [LANES-1:0]   lane_live_next;
    logic [LANES-1:0]   lane_live;
    logic [PC_BITS-1:0] min_pc;
    logic               any_live;
    logic [LANES-1:0]   min_mask;
    logic               past_end;

    // Counters.
    logic [STEP_W-1:0]     step_next;
    logic [LANE_OPS_W-1:0] lane_ops_next;
    logic [WEIGHT_W-1:0]   weighted_next;

    // Result buffer.
    logic [RES_W-1:0] result;
    logic [RES_W-1:0] out_data_reg;
    logic [RES_W-1:0] out_data_next;
    logic [RES_W-1:0] skid_data_reg;
    logic [RES_W-1:0] skid_data_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;

    // Action decode.
    always_comb
    begin
        is_launch = 1'b0;
        is_retire = 1'b0;
        is_clear  = 1'b0;
        unique case (action_t'(action))
            ACT_LAUNCH: is_launch = 1'b1;
            ACT_RETIRE: is_retire = 1'b1;
            ACT_CLEAR:  is_clear  = 1'b1;
            default:    ;
        endcase
    end

    // Lanes that take the branch target.
    always_comb
    begin
        jumpers = '0;
        unique case (outcome_t'(outcome_kind)) inside
            OUT_JUMP:             jumpers = current_mask_reg;
            OUT_BRANCH:           jumpers = current_mask_reg & taken_mask;
            OUT_FALL, OUT_RETURN: jumpers = '0;
            default:              jumpers = '0;
        endcase
    end

    // Target pc with a sign check and saturation at the largest pc.
    assign target      = TW'(current_pc_reg) + {{(TW-OFFSET_W){branch_offset[OFFSET_W-1]}},
                                                branch_offset};
    assign target_neg  = target[TW-1];
    assign target_over = |target[TW-2:PC_BITS];
    assign jump_pc     = target_over ? '1 : target[PC_BITS-1:0];
    assign fall_pc     = (&current_pc_reg) ? current_pc_reg : current_pc_reg + 1'b1;

    // A retire counts only with something issued and no fault pending.
    assign retire_hit = in_acc && is_retire && (fault_reg == FAULT_NONE) &&
                        (current_mask_reg != '0);
    assign neg_fault  = retire_hit && (jumpers != '0) && target_neg;

    assign lane_ctl.launch = in_acc && is_launch;
    assign lane_ctl.apply  = retire_hit && !neg_fault;
    assign lane_ctl.kill   = (outcome_t'(outcome_kind) == OUT_RETURN);

    assign stats_ctl.count = lane_ctl.apply;
    assign stats_ctl.clear = in_acc && is_clear;

    // Lanes.
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        smpi_lane #(
            .PC_BITS (PC_BITS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (lane_ctl),
            .launch_bit (launch_mask[i]),
            .issued_bit (current_mask_reg[i]),
            .jump_bit   (jumpers[i]),
            .start_pc   (start_pc),
            .jump_pc    (jump_pc),
            .fall_pc    (fall_pc),
            .pc_next    (lane_pc_next[i]),
            .live_next  (lane_live_next[i]),
            .live       (lane_live[i])
        );
    end

    // Minimum pc over the updated lanes.
    smpi_merge #(
        .LANES   (LANES),
        .PC_BITS (PC_BITS)
    ) u_merge (
        .lane_pc   (lane_pc_next),
        .lane_live (lane_live_next),
        .min_pc    (min_pc),
        .any_live  (any_live),
        .min_mask  (min_mask)
    );

    // Statistics counters.
    smpi_stats #(
        .LANES (LANES)
    ) u_stats (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (stats_ctl),
        .issued_mask   (current_mask_reg),
        .cost          (cost),
        .step_next     (step_next),
        .lane_ops_next (lane_ops_next),
        .weighted_next (weighted_next)
    );

    // Fault after the action, then the past-end check on the new issue pc.
    assign past_end = CW'(min_pc) >= CW'(program_length_reg);

    always_comb
    begin
        fault_mid = fault_reg;
        if (lane_ctl.launch)
        begin
            fault_mid = FAULT_NONE;
        end
        else if (neg_fault)
        begin
            fault_mid = FAULT_NEG_TARGET;
        end
        fault_next = fault_mid;
        if (in_acc && any_live && (fault_mid == FAULT_NONE) && past_end)
        begin
            fault_next = FAULT_PAST_END;
        end
    end

    assign result = {min_pc, min_mask, !any_live, fault_next,
                     step_next, lane_ops_next, weighted_next};

    // Issue state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_length_reg <= '0;
            current_pc_reg     <= '0;
            current_mask_reg   <= '0;
            fault_reg          <= FAULT_NONE;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                program_length_reg <= cfg_wr_data;
            end
            fault_reg <= fault_next;
            if (in_acc)
            begin
                current_pc_reg   <= min_pc;
                current_mask_reg <= min_mask;
            end
        end
    end

    // Output register with a skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_acc)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_acc;
                out_data_next  = result;
            end
        end
        else if (in_acc)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Unpack the result register onto the ports.
    assign out_valid = out_valid_reg;
    assign {issue_pc, issue_mask, warp_done, fault_code,
            step_count, lane_op_count, weighted_op_count} = out_data_reg;

`ifndef SYNTHESIS
    // The skid entry only fills behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // Issued lanes are always live.
    a_issue_live: assert property (@(posedge clk) disable iff (!rst_n)
        (current_mask_reg & ~lane_live) == '0)
        else $error("issued lane is not live");

    // With nothing issued the issue pc reads zero.
    a_idle_pc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (current_mask_reg == '0) |-> (current_pc_reg == '0))
        else $error("issue pc nonzero with empty mask");

    // A launch never leaves a negative-target fault behind.
    a_launch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && is_launch) |=> (fault_reg != FAULT_NEG_TARGET))
        else $error("negative-target fault survived a launch");

    // A stalled input is never taken, so a full buffer blocks new results.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result buffer lost an entry");
`endif

endmodule

`default_nettype wire

### dv/simt_min_pc_warp_issue_checker.sv
// Checker for the min-pc warp issue block: watches both channels, predicts and compares results.
module simt_min_pc_warp_issue_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wr_en,
    input  wire [smpi_pkg::PROG_LEN_W-1:0]      cfg_wr_data,
    input  wire                                 in_valid,
    input  wire                                 in_stall,
    input  wire [1:0]                           action,
    input  wire [smpi_pkg::DEF_PC_BITS-1:0]     start_pc,
    input  wire [smpi_pkg::DEF_LANES-1:0]       launch_mask,
    input  wire [1:0]                           outcome_kind,
    input  wire [smpi_pkg::DEF_LANES-1:0]       taken_mask,
    input  wire [smpi_pkg::OFFSET_W-1:0]        branch_offset,
    input  wire [smpi_pkg::COST_W-1:0]          cost,
    input  wire                                 out_valid,
    input  wire                                 out_stall,
    input  wire [smpi_pkg::DEF_PC_BITS-1:0]     issue_pc,
    input  wire [smpi_pkg::DEF_LANES-1:0]       issue_mask,
    input  wire                                 warp_done,
    input  wire [smpi_pkg::FAULT_W-1:0]         fault_code,
    input  wire [smpi_pkg::STEP_W-1:0]          step_count,
    input  wire [smpi_pkg::LANE_OPS_W-1:0]      lane_op_count,
    input  wire [smpi_pkg::WEIGHT_W-1:0]        weighted_op_count,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  applied_count,
    output int                                  checked_count
);
    import smpi_pkg::*;

    localparam int LANES       = DEF_LANES;
    localparam int PC_BITS     = DEF_PC_BITS;
    localparam int PC_TOP      = (1 << PC_BITS) - 1;
    localparam int MAX_REPORTS = 100;

    // One issue result as the block should report it.
    typedef struct packed {
        logic [PC_BITS-1:0]    pc;
        logic [LANES-1:0]      mask;
        logic                  done;
        logic [FAULT_W-1:0]    fault;
        logic [STEP_W-1:0]     steps;
        logic [LANE_OPS_W-1:0] lane_ops;
        logic [WEIGHT_W-1:0]   weighted;
    } issue_result_t;

    // Shadow copy of the warp and of the program length register.
    logic [PC_BITS-1:0]    lane_pc_q [LANES];
    logic [LANES-1:0]      lane_live_q;
    logic [PC_BITS-1:0]    issued_pc;
    logic [LANES-1:0]      issued_mask;
    fault_t                warp_fault;
    logic [STEP_W-1:0]     steps_q;
    logic [LANE_OPS_W-1:0] lane_ops_q;
    logic [WEIGHT_W-1:0]   weighted_q;
    logic [PROG_LEN_W-1:0] prog_len_q;

    issue_result_t expected_issues[$];
    int            mismatches;
    int            applied;
    int            checked;

    task automatic clear_warp_shadow();
        for (int i = 0; i < LANES; i++)
        begin
            lane_pc_q[i] = '0;
        end
        lane_live_q = '0;
        issued_pc   = '0;
        issued_mask = '0;
        warp_fault  = FAULT_NONE;
        steps_q     = '0;
        lane_ops_q  = '0;
        weighted_q  = '0;
        prog_len_q  = '0;
    endtask

    // Apply the issued instruction's outcome to the issued lanes.
    task automatic retire_issued(input logic [1:0] kind, input logic [LANES-1:0] taken,
                                 input logic signed [OFFSET_W-1:0] offset,
                                 input logic [COST_W-1:0] weight);
        int                    pc_i;
        int                    off_i;
        int                    target_i;
        logic [PC_BITS-1:0]    target;
        logic [PC_BITS-1:0]    next_pc;
        logic [LANES-1:0]      jumpers;
        int                    lanes_n;
        logic [LANE_OPS_W:0]   lane_sum;
        logic [WEIGHT_W:0]     weight_sum;
        pc_i     = issued_pc;
        off_i    = offset;
        target_i = pc_i + off_i;
        if (kind == OUT_JUMP)
            jumpers = issued_mask;
        else if (kind == OUT_BRANCH)
            jumpers = issued_mask & taken;
        else
            jumpers = '0;

        // A taken branch below pc zero faults and leaves everything else alone.
        if (jumpers != '0 && target_i < 0)
        begin
            warp_fault = FAULT_NEG_TARGET;
            return;
        end
        if (target_i < 0)
            target = '0;
        else if (target_i > PC_TOP)
            target = '1;
        else
            target = target_i[PC_BITS-1:0];
        next_pc = (issued_pc == '1) ? issued_pc : issued_pc + 1'b1;

        for (int i = 0; i < LANES; i++)
        begin
            if (issued_mask[i])
            begin
                if (kind == OUT_RETURN)
                    lane_live_q[i] = 1'b0;
                else if (jumpers[i])
                    lane_pc_q[i] = target;
                else
                    lane_pc_q[i] = next_pc;
            end
        end

        // Saturating statistics.
        lanes_n    = $countones(issued_mask);
        lane_sum   = {1'b0, lane_ops_q} + lanes_n;
        weight_sum = {1'b0, weighted_q} + lanes_n * weight;
        if (steps_q != '1)
            steps_q = steps_q + 1'b1;
        lane_ops_q = lane_sum[LANE_OPS_W] ? '1 : lane_sum[LANE_OPS_W-1:0];
        weighted_q = weight_sum[WEIGHT_W] ? '1 : weight_sum[WEIGHT_W-1:0];
    endtask

    // Work out the warp's next state for one item and the issue result it reports.
    task automatic advance_warp(output issue_result_t res);
        logic               any_live;
        logic [PC_BITS-1:0] min_pc;
        logic [LANES-1:0]   at_min;
        any_live = 1'b0;
        min_pc   = '0;
        at_min   = '0;
        if (action == ACT_LAUNCH)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                lane_live_q[i] = launch_mask[i];
                if (launch_mask[i])
                    lane_pc_q[i] = start_pc;
            end
            warp_fault = FAULT_NONE;
            applied++;
        end
        else if (action == ACT_RETIRE)
        begin
            // Retires are dropped while faulted or while nothing is issued.
            if (warp_fault == FAULT_NONE && issued_mask != '0)
            begin
                retire_issued(outcome_kind, taken_mask, branch_offset, cost);
                applied++;
            end
        end
        else if (action == ACT_CLEAR)
        begin
            steps_q    = '0;
            lane_ops_q = '0;
            weighted_q = '0;
            applied++;
        end

        // Lowest live pc and the lanes sitting at it.
        for (int i = 0; i < LANES; i++)
        begin
            if (lane_live_q[i] && (!any_live || lane_pc_q[i] < min_pc))
            begin
                min_pc   = lane_pc_q[i];
                any_live = 1'b1;
            end
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (lane_live_q[i] && lane_pc_q[i] == min_pc)
                at_min[i] = 1'b1;
        end
        issued_pc   = any_live ? min_pc : '0;
        issued_mask = any_live ? at_min : '0;
        if (any_live && warp_fault == FAULT_NONE && min_pc >= prog_len_q)
            warp_fault = FAULT_PAST_END;

        res.pc       = issued_pc;
        res.mask     = issued_mask;
        res.done     = (issued_mask == '0);
        res.fault    = warp_fault;
        res.steps    = steps_q;
        res.lane_ops = lane_ops_q;
        res.weighted = weighted_q;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
        end
    endfunction

    // Compare accepted results first, then record the item taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        issue_result_t want;
        issue_result_t next_res;
        if (!rst_n)
        begin
            clear_warp_shadow();
            expected_issues.delete();
            mismatches    = 0;
            applied       = 0;
            checked       = 0;
            fail_count    <= 0;
            pending_count <= 0;
            applied_count <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                prog_len_q = cfg_wr_data;

            if (out_valid && !out_stall)
            begin
                if (expected_issues.size() == 0)
                begin
                    mismatches++;
                    $error("issue result arrived with no item waiting for it");
                end
                else
                begin
                    want = expected_issues.pop_front();
                    check_field("issue_pc", want.pc, issue_pc);
                    check_field("issue_mask", want.mask, issue_mask);
                    check_field("warp_done", want.done, warp_done);
                    check_field("fault_code", want.fault, fault_code);
                    check_field("step_count", want.steps, step_count);
                    check_field("lane_op_count", want.lane_ops, lane_op_count);
                    check_field("weighted_op_count", want.weighted, weighted_op_count);
                    checked++;
                end
            end

            if (in_valid && !in_stall)
            begin
                advance_warp(next_res);
                expected_issues.push_back(next_res);
            end

            fail_count    <= mismatches;
            pending_count <= expected_issues.size();
            applied_count <= applied;
            checked_count <= checked;
        end
    end

endmodule

### dv/simt_min_pc_warp_issue_tb.sv
// Testbench top for the min-pc warp issue block: clock, reset, stimulus and verdict.
module simt_min_pc_warp_issue_tb;
    import smpi_pkg::*;

    localparam int          LANES        = DEF_LANES;
    localparam int          PC_BITS      = DEF_PC_BITS;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PHASE_ITEMS  = 120;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam int          NUM_PHASES   = 10;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [PROG_LEN_W-1:0]  cfg_wr_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             action;
    logic [PC_BITS-1:0]     start_pc;
    logic [LANES-1:0]       launch_mask;
    logic [1:0]             outcome_kind;
    logic [LANES-1:0]       taken_mask;
    logic [OFFSET_W-1:0]    branch_offset;
    logic [COST_W-1:0]      cost;
    logic                   out_valid;
    logic                   out_stall;
    logic [PC_BITS-1:0]     issue_pc;
    logic [LANES-1:0]       issue_mask;
    logic                   warp_done;
    logic [FAULT_W-1:0]     fault_code;
    logic [STEP_W-1:0]      step_count;
    logic [LANE_OPS_W-1:0]  lane_op_count;
    logic [WEIGHT_W-1:0]    weighted_op_count;

    int                     fail_count;
    int                     pending_count;
    int                     applied_count;
    int                     checked_count;

    int                     cycles = 0;
    int                     items_sent = 0;
    int                     launches = 0;
    logic                   calm = 1'b0;
    logic [PROG_LEN_W-1:0]  prog_len_now = '0;

    simt_min_pc_warp_issue dut (.*);

    simt_min_pc_warp_issue_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simt_min_pc_warp_issue_tb: FAIL");
            $finish;
        end
    end

    // Idle cycles a side waits before its next item; none during a calm stretch.
    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // Receiver: stall a random number of cycles before each result it takes.
    initial
    begin
        int gap;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = idle_draw();
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Offer one item after a random gap and hold it until it is taken.
    task automatic send_item(input logic [1:0] act, input logic [PC_BITS-1:0] spc,
                             input logic [LANES-1:0] lmask, input logic [1:0] kind,
                             input logic [LANES-1:0] taken, input logic signed [15:0] off,
                             input logic [COST_W-1:0] cst);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        start_pc      <= spc;
        launch_mask   <= lmask;
        outcome_kind  <= kind;
        taken_mask    <= taken;
        branch_offset <= off;
        cost          <= cst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (act == ACT_LAUNCH)
            launches++;
    endtask

    // Stop offering items and wait for every predicted result to come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_program_length(input logic [PROG_LEN_W-1:0] len);
        drain_results();
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= len;
        prog_len_now = len;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), PC_BITS'($urandom), $urandom, 2'($urandom),
                  $urandom, 16'($urandom), COST_W'($urandom));
    endtask

    // A launched warp followed by a run of retires that diverge and reconverge.
    task automatic run_warp_program();
        int                 steps;
        int                 pick;
        outcome_t           kind;
        logic [LANES-1:0]   lmask;
        logic [PC_BITS-1:0] spc;
        logic signed [15:0] off;
        calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
            0: lmask = '1;
            1: lmask = 32'h1 << $urandom_range(0, LANES - 1);
            default: lmask = $urandom;
        endcase
        spc = (prog_len_now > 2) ? PC_BITS'($urandom_range(0, prog_len_now / 2)) : '0;
        send_item(ACT_LAUNCH, spc, lmask, 2'($urandom), $urandom, 16'($urandom),
                  COST_W'($urandom));
        steps = $urandom_range(4, 30);
        repeat (steps)
        begin
            pick = $urandom_range(0, 19);
            if ($urandom_range(0, 19) == 0)
                off = 16'($urandom);
            else
                off = 16'($urandom_range(0, 18) - 6);
            if (pick < 8)
                kind = OUT_FALL;
            else if (pick < 14)
                kind = OUT_BRANCH;
            else if (pick < 16)
                kind = OUT_JUMP;
            else
                kind = OUT_RETURN;
            if (pick == 18)
                send_item(ACT_CLEAR, PC_BITS'($urandom), $urandom, 2'($urandom), $urandom,
                          off, COST_W'($urandom));
            else if (pick == 19)
                send_noise();
            else
                send_item(ACT_RETIRE, PC_BITS'($urandom), $urandom, kind, $urandom, off,
                          COST_W'($urandom));
        end
        // Often finish the warp off so that done is reached.
        if ($urandom_range(0, 1) == 1)
        begin
            repeat (8)
                send_item(ACT_RETIRE, PC_BITS'($urandom), $urandom, OUT_RETURN, $urandom,
                          16'($urandom), COST_W'($urandom));
        end
    endtask

    initial
    begin
        logic [PROG_LEN_W-1:0] lengths [NUM_PHASES];
        int                    phase_base;
        lengths = '{16'hFFFF, 16'd64, 16'd1, 16'd16, 16'd0, 16'd200, 16'hFFFF,
                    16'd0, 16'd32, 16'd2};
        lengths[7] = PROG_LEN_W'($urandom_range(3, 1000));

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        in_valid      <= 1'b0;
        action        <= ACT_LAUNCH;
        start_pc      <= '0;
        launch_mask   <= '0;
        outcome_kind  <= OUT_FALL;
        taken_mask    <= '0;
        branch_offset <= '0;
        cost          <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Program length zero from reset: every issue is past the end.
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_FALL, 32'h0, 16'sd0, 4'd5);
        send_item(ACT_LAUNCH, 16'h0, '1, OUT_FALL, 32'h0, 16'sd0, 4'd0);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_JUMP, '1, 16'sd3, 4'd15);
        send_item(ACT_UNUSED, '1, '1, OUT_RETURN, '1, -16'sd1, 4'd15);
        send_item(ACT_CLEAR, 16'h0, 32'h0, OUT_FALL, 32'h0, 16'sd0, 4'd0);

        write_program_length(16'hFFFF);
        // Jump target above the largest pc saturates and then faults past the end.
        send_item(ACT_LAUNCH, 16'd65000, '1, OUT_FALL, 32'h0, 16'sd0, 4'd0);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_JUMP, 32'h0, 16'sd32767, 4'd15);
        // Empty launch: done, and a retire with nothing issued is dropped.
        send_item(ACT_LAUNCH, 16'h1234, 32'h0, OUT_FALL, 32'h0, 16'sd0, 4'd0);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_FALL, 32'h0, 16'sd0, 4'd9);
        // Jump below pc zero faults, and the fault sticks.
        send_item(ACT_LAUNCH, 16'h0, '1, OUT_FALL, 32'h0, 16'sd0, 4'd0);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_JUMP, 32'h0, -16'sd1, 4'd3);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_FALL, 32'h0, 16'sd0, 4'd3);
        // Divergence on a conditional branch, then reconvergence at the lowest pc.
        send_item(ACT_LAUNCH, 16'd10, 32'h0000FFFF, OUT_FALL, 32'h0, 16'sd0, 4'd0);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_BRANCH, 32'h00005555, 16'sd5, 4'd15);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_BRANCH, 32'h0, -16'sd32768, 4'd0);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_JUMP, 32'h0, 16'sd2, 4'd7);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_RETURN, 32'h0, 16'sd0, 4'd1);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_BRANCH, '1, -16'sd15, 4'd2);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_BRANCH, 32'h1, 16'sd32767, 4'd4);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_RETURN, 32'h0, 16'sd0, 4'd8);
        send_item(ACT_RETIRE, 16'h0, 32'h0, OUT_RETURN, 32'h0, 16'sd0, 4'd8);
        // Lane extremes and the largest start pc.
        send_item(ACT_LAUNCH, '1, 32'h80000000, OUT_FALL, 32'h0, 16'sd0, 4'd0);
        send_item(ACT_LAUNCH, 16'h1, 32'h1, OUT_FALL, 32'h0, 16'sd0, 4'd0);
        send_item(ACT_RETIRE, '1, '1, OUT_FALL, '1, -16'sd1, 4'd15);
        send_item(ACT_CLEAR, 16'h0, 32'h0, OUT_FALL, 32'h0, 16'sd0, 4'd0);

        // Random warp programs over several program lengths.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_program_length(lengths[p]);
            phase_base = items_sent;
            while (items_sent - phase_base < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 5))
                        send_noise();
                end
                else
                begin
                    run_warp_program();
                end
            end
        end

        drain_results();
        $display("Sent %0d items (%0d launches, %0d took effect); checked %0d results.",
                 items_sent, launches, applied_count, checked_count);
        $display("Program lengths ran from 0 to 65535 over %0d random phases.", NUM_PHASES);
        if (fail_count == 0 && pending_count == 0)
            $display("simt_min_pc_warp_issue_tb: PASS");
        else
            $display("simt_min_pc_warp_issue_tb: FAIL");
        $finish;
    end

endmodule
